// ===== sv/sha_pkg.sv =====
// shared types, constants and round functions for the sha-256 stream hasher
package sha_pkg;

    localparam int BlockWords = 16;
    localparam int HashWords  = 8;
    localparam int Rounds     = 64;
    localparam int BlockBytes = BlockWords * 4;
    localparam int PosW       = $clog2(BlockBytes);
    localparam int TotalW     = 61;

    localparam logic [PosW-1:0] LenPos  = PosW'(BlockBytes - 8);
    localparam logic [PosW-1:0] LastPos = PosW'(BlockBytes - 1);
    localparam logic [7:0]      PadByte = 8'h80;
    localparam logic [2:0]      WordBytes = 3'd4;

    // input request
    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  valid_bytes;
        logic        last_word;
    } hash_in_t;

    // output request
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  digest_index;
        logic        digest_last;
    } hash_out_t;

    // sequencer to compression core
    typedef struct packed {
        logic start;
        logic init;
    } core_ctrl_t;

    // compression core to sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

    function automatic logic [31:0] hash_init(input logic [2:0] idx);
        logic [31:0] v;
        unique case (idx)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            3'd7: v = 32'h5be0cd19;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] v;
        unique case (idx)
            6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
            6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
            6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
            6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
            6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
            6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
            6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
            6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
            6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
            6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
            6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
            6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
            6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
            6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
            6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
            6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
            6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
            6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
            6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
            6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
            6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
            6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
            6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
            6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
            6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
            6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
            6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
            6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
            6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
            6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
            6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
            6'd62: v = 32'hbef9a3f7;  6'd63: v = 32'hc67178f2;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

// ===== sv/sha_core.sv =====
// sha-256 compression core: one round per cycle with a rolling message schedule
module sha_core
    import sha_pkg::*;
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  core_ctrl_t                       ctrl,
    input  logic [BlockWords-1:0][31:0]      block,
    output core_stat_t                       stat,
    output logic [HashWords-1:0][31:0]       hash
);

    typedef enum logic [1:0] {C_IDLE, C_RUN, C_ADD} core_state_t;

    core_state_t                   state_reg;
    logic [5:0]                    round_reg;
    logic [HashWords-1:0][31:0]    hash_reg;
    logic [31:0]                   w_reg [BlockWords];
    logic [31:0]                   v_reg [HashWords];

    logic [31:0] w_new;
    logic [31:0] ch;
    logic [31:0] maj;
    logic [31:0] t1;
    logic [31:0] t2;

    // next schedule word and round function
    always_comb
    begin
        w_new = w_reg[0] + small_sigma0(w_reg[1]) + w_reg[9] + small_sigma1(w_reg[14]);
        ch    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        maj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1    = v_reg[7] + big_sigma1(v_reg[4]) + ch + round_k(round_reg) + w_reg[0];
        t2    = big_sigma0(v_reg[0]) + maj;
    end

    // sequencer and chaining value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            round_reg <= '0;
            for (int i = 0; i < HashWords; i++)
            begin
                hash_reg[i] <= hash_init(3'(i));
            end
        end
        else
        begin
            unique case (state_reg)
                C_IDLE:
                begin
                    if (ctrl.init)
                    begin
                        for (int i = 0; i < HashWords; i++)
                        begin
                            hash_reg[i] <= hash_init(3'(i));
                        end
                    end
                    if (ctrl.start)
                    begin
                        state_reg <= C_RUN;
                        round_reg <= '0;
                    end
                end
                C_RUN:
                begin
                    round_reg <= round_reg + 6'd1;
                    if (round_reg == 6'(Rounds - 1))
                    begin
                        state_reg <= C_ADD;
                    end
                end
                C_ADD:
                begin
                    for (int i = 0; i < HashWords; i++)
                    begin
                        hash_reg[i] <= hash_reg[i] + v_reg[i];
                    end
                    state_reg <= C_IDLE;
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    // working variables and schedule window
    always_ff @(posedge clk)
    begin
        if (state_reg == C_IDLE && ctrl.start)
        begin
            for (int i = 0; i < BlockWords; i++)
            begin
                w_reg[i] <= block[i];
            end
            for (int i = 0; i < HashWords; i++)
            begin
                v_reg[i] <= hash_reg[i];
            end
        end
        else if (state_reg == C_RUN)
        begin
            for (int i = 0; i < BlockWords - 1; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[BlockWords-1] <= w_new;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    assign stat.busy = (state_reg != C_IDLE);
    assign stat.done = (state_reg == C_ADD);
    assign hash      = hash_reg;

endmodule

// ===== sv/sha256_stream_hasher.sv =====
// sha-256 stream hasher top level: byte packing, padding, digest output
//
// Takes a message as big-endian 32-bit words and returns its sha-256 digest as
// eight words, index 0 first. Words are taken only while data_stall is low; a
// taken word is registered and its valid bytes are then packed into the block
// buffer one at a time; no new word is taken until they are written. Each
// filled 64-byte block goes through the compression core, which runs one round
// per cycle; no word is taken during a compression. After the last word the
// padding, including the 64-bit bit length, is written one byte per cycle
// between compressions (up to 72 bytes) and costs one or two more compressions;
// the eight digest words then follow, one per cycle while digest_stall is low,
// and the hasher returns to its initial hash values.
module sha256_stream_hasher
    import sha_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      data_valid,
    output logic      data_stall,
    input  hash_in_t  data,
    output logic      digest_valid,
    input  logic      digest_stall,
    output hash_out_t digest
);

    typedef enum logic [2:0] {S_IDLE, S_BYTES, S_PAD, S_START, S_WAIT, S_EMIT} state_t;

    state_t              state_reg;
    logic [31:0]         word_reg;
    logic [2:0]          nv_reg;
    logic [2:0]          cnt_reg;
    logic                last_reg;
    logic [PosW-1:0]     pos_reg;
    logic [TotalW-1:0]   total_reg;
    logic                pad80_reg;
    logic                len_ok_reg;
    logic                final_reg;
    logic [2:0]          idx_reg;

    logic [31:0]                 buf_reg [BlockWords];
    logic [BlockWords-1:0][31:0] block_words;
    logic [HashWords-1:0][31:0]  hash;

    core_ctrl_t  core_ctrl;
    core_stat_t  core_stat;

    logic        accept;
    logic        out_take;
    logic [2:0]  nv_clamp;
    logic        wr_en;
    logic [7:0]  wr_byte;
    logic [63:0] len_bits;
    logic [7:0]  len_byte;
    logic [4:0]  lane_off;
    logic        bytes_left;

    assign accept   = data_valid && !data_stall;
    assign out_take = digest_valid && !digest_stall;
    assign nv_clamp = (data.valid_bytes > WordBytes) ? WordBytes : data.valid_bytes;

    // byte to write into the block buffer
    always_comb
    begin
        len_bits   = {3'b000, total_reg} << 3;
        len_byte   = len_bits[{~pos_reg[2:0], 3'b000} +: 8];
        lane_off   = {~pos_reg[1:0], 3'b000};
        bytes_left = (cnt_reg + 3'd1) != nv_reg;
        wr_en      = (state_reg == S_BYTES) || (state_reg == S_PAD);
        if (state_reg == S_BYTES)
        begin
            wr_byte = word_reg[{~cnt_reg[1:0], 3'b000} +: 8];
        end
        else if (!pad80_reg)
        begin
            wr_byte = PadByte;
        end
        else if (len_ok_reg && pos_reg >= LenPos)
        begin
            wr_byte = len_byte;
        end
        else
        begin
            wr_byte = 8'h00;
        end
    end

    // block buffer, byte lane writes
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            buf_reg[pos_reg[PosW-1:2]][lane_off +: 8] <= wr_byte;
        end
    end

    always_comb
    begin
        for (int i = 0; i < BlockWords; i++)
        begin
            block_words[i] = buf_reg[i];
        end
    end

    // message sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            word_reg   <= '0;
            nv_reg     <= '0;
            cnt_reg    <= '0;
            last_reg   <= 1'b0;
            pos_reg    <= '0;
            total_reg  <= '0;
            pad80_reg  <= 1'b0;
            len_ok_reg <= 1'b0;
            final_reg  <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        word_reg <= data.data_word;
                        nv_reg   <= nv_clamp;
                        cnt_reg  <= '0;
                        last_reg <= data.last_word;
                        if (nv_clamp != 3'd0)
                        begin
                            state_reg <= S_BYTES;
                        end
                        else if (data.last_word)
                        begin
                            state_reg <= S_PAD;
                        end
                    end
                end
                S_BYTES:
                begin
                    pos_reg   <= pos_reg + PosW'(1);
                    total_reg <= total_reg + TotalW'(1);
                    cnt_reg   <= cnt_reg + 3'd1;
                    if (pos_reg == LastPos)
                    begin
                        state_reg <= S_START;
                    end
                    else if (!bytes_left)
                    begin
                        state_reg <= last_reg ? S_PAD : S_IDLE;
                    end
                end
                S_PAD:
                begin
                    pos_reg <= pos_reg + PosW'(1);
                    if (!pad80_reg)
                    begin
                        pad80_reg  <= 1'b1;
                        len_ok_reg <= (pos_reg < LenPos);
                    end
                    if (pos_reg == LastPos)
                    begin
                        final_reg <= pad80_reg && len_ok_reg;
                        state_reg <= S_START;
                    end
                end
                S_START:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (core_stat.done)
                    begin
                        if (final_reg)
                        begin
                            idx_reg   <= '0;
                            state_reg <= S_EMIT;
                        end
                        else if (pad80_reg)
                        begin
                            len_ok_reg <= 1'b1;
                            state_reg  <= S_PAD;
                        end
                        else if (cnt_reg != nv_reg)
                        begin
                            state_reg <= S_BYTES;
                        end
                        else if (last_reg)
                        begin
                            state_reg <= S_PAD;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (!digest_stall)
                    begin
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'(HashWords - 1))
                        begin
                            total_reg  <= '0;
                            pad80_reg  <= 1'b0;
                            len_ok_reg <= 1'b0;
                            final_reg  <= 1'b0;
                            state_reg  <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // core control
    assign core_ctrl.start = (state_reg == S_START);
    assign core_ctrl.init  = (state_reg == S_EMIT) && !digest_stall
                             && (idx_reg == 3'(HashWords - 1));

    sha_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (core_ctrl),
        .block (block_words),
        .stat  (core_stat),
        .hash  (hash)
    );

    // handshake outputs
    assign data_stall          = (state_reg != S_IDLE);
    assign digest_valid        = (state_reg == S_EMIT);
    assign digest.digest_word  = hash[idx_reg];
    assign digest.digest_index = idx_reg;
    assign digest.digest_last  = (idx_reg == 3'(HashWords - 1));

    // no request taken while the digest is being delivered
    assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> data_stall)
        else $error("input taken during digest output");

    // digest words leave in order
    assert property (@(posedge clk) disable iff (!rst_n)
        out_take && !digest.digest_last |=>
            digest_valid && digest.digest_index == $past(digest.digest_index) + 3'd1)
        else $error("digest index out of order");

    // output ends after the final digest word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_take && digest.digest_last |=> !digest_valid && !core_stat.busy)
        else $error("digest output did not end");

    // the core only finishes a block the sequencer is waiting on
    assert property (@(posedge clk) disable iff (!rst_n)
        core_stat.done |-> state_reg == S_WAIT)
        else $error("compression finished outside wait");

endmodule
